>>> rtl/strict_priority_packet_queue_assert.svh
// Assertion macros used by the checker file.
`ifndef STRICT_PRIORITY_PACKET_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_PACKET_QUEUE_ASSERT_SVH

// Checks that cond_a implies cond_b in the same cycle.
`define SPPQ_ASSERT_IMPLY(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
      else $error("assertion failed");

// Checks that cond_a implies cond_b in the next cycle.
`define SPPQ_ASSERT_NEXT(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
      else $error("assertion failed");

`endif

>>> rtl/sppq_pkg.sv
package sppq_pkg;

   localparam int NUM_LEVELS  = 8;
   localparam int QUEUE_LIMIT = 8;
   localparam int MAX_SEND    = 64;

   localparam int SLOTS     = QUEUE_LIMIT + 1;
   localparam int KEPT      = QUEUE_LIMIT / 2 + 1;
   localparam int DROP      = SLOTS - KEPT;
   localparam int DROP_SAT  = (DROP > 15) ? 15 : DROP;
   localparam int LVL_W     = $clog2(NUM_LEVELS);
   localparam int PW        = $clog2(SLOTS);
   localparam int MEM_DEPTH = NUM_LEVELS * SLOTS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   localparam logic       OP_RECV      = 1'b0;
   localparam logic       OP_SEND      = 1'b1;
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_SENT    = 2'd1;
   localparam logic [1:0] KIND_NOTHING = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          latch;
      logic          append;
      logic          thin_rd;
      logic          thin_wr;
      logic          thin_set;
      logic          pop;
      logic          load;
      logic [1:0]    load_kind;
      logic          load_drop;
      logic          load_last;
      logic [PW-1:0] k;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_range;
      logic old_full;
      logic any_nonempty;
   } status_type;

   // Ring position: sum is below twice the slot count.
   function automatic logic [PW-1:0] wrap_pos(input logic [PW:0] s);
      logic [PW:0] r;
      r = (s >= (PW+1)'(SLOTS)) ? s - (PW+1)'(SLOTS) : s;
      return r[PW-1:0];
   endfunction

endpackage

>>> rtl/sppq_datapath.sv
module sppq_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sppq_pkg::cmd_type      cmd,
   output sppq_pkg::status_type   status,
   input  logic [2:0]             req_prio_level,
   input  logic [15:0]            req_packet_handle,
   output logic [1:0]             rsp_result_kind,
   output logic [15:0]            rsp_out_handle,
   output logic [2:0]             rsp_out_level,
   output logic [3:0]             rsp_dropped_count,
   output logic                   rsp_last_flag
);
   import sppq_pkg::*;

   logic [15:0]      mem [MEM_DEPTH];
   logic [15:0]      rd_data_ff;
   logic [LVL_W-1:0] lvl_ff;
   logic [15:0]      handle_ff;
   logic             in_range_ff;
   logic [LVL_W-1:0] pop_lvl_ff;
   logic [PW-1:0]    head_ff [NUM_LEVELS];
   logic [PW-1:0]    fill_ff [NUM_LEVELS];
   logic [LVL_W-1:0] top_lvl;
   logic             any_ne;
   logic [LVL_W-1:0] acc_lvl;
   logic [PW-1:0]    pos;
   logic [ADDR_W-1:0] addr;
   logic [1:0]       kind_ff;
   logic [15:0]      ohandle_ff;
   logic [2:0]       olevel_ff;
   logic [3:0]       drop_ff;
   logic             last_ff;

   // Highest non-empty level.
   always_comb begin
      top_lvl = '0;
      any_ne  = 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (fill_ff[i] != '0) begin
            top_lvl = LVL_W'(i);
            any_ne  = 1'b1;
         end
      end
   end

   // Slot address of the current access.
   always_comb begin
      acc_lvl = cmd.pop ? top_lvl : lvl_ff;
      priority if (cmd.append) begin
         pos = wrap_pos({1'b0, head_ff[lvl_ff]} + {1'b0, fill_ff[lvl_ff]});
      end else if (cmd.thin_rd) begin
         pos = wrap_pos({1'b0, head_ff[lvl_ff]} + {cmd.k, 1'b0});
      end else if (cmd.thin_wr) begin
         pos = wrap_pos({1'b0, head_ff[lvl_ff]} + {1'b0, cmd.k});
      end else begin
         pos = head_ff[top_lvl];
      end
      addr = ADDR_W'(acc_lvl) * ADDR_W'(SLOTS) + ADDR_W'(pos);
   end

   assign status.in_range     = in_range_ff;
   assign status.old_full     = (fill_ff[lvl_ff] == PW'(QUEUE_LIMIT));
   assign status.any_nonempty = any_ne;

   // Slot memory with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[addr] <= handle_ff;
      end else if (cmd.thin_wr) begin
         mem[addr] <= rd_data_ff;
      end
      if (cmd.thin_rd || cmd.pop) begin
         rd_data_ff <= mem[addr];
      end
   end

   // Request fields and pop level.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         lvl_ff      <= LVL_W'(req_prio_level);
         handle_ff   <= req_packet_handle;
         in_range_ff <= (32'(req_prio_level) < NUM_LEVELS);
      end
      if (cmd.pop) begin
         pop_lvl_ff <= top_lvl;
      end
   end

   // Ring pointers of each level.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (cmd.append) begin
         fill_ff[lvl_ff] <= fill_ff[lvl_ff] + PW'(1);
      end else if (cmd.thin_set) begin
         fill_ff[lvl_ff] <= PW'(KEPT);
      end else if (cmd.pop) begin
         head_ff[top_lvl] <= wrap_pos({1'b0, head_ff[top_lvl]} + (PW+1)'(1));
         fill_ff[top_lvl] <= fill_ff[top_lvl] - PW'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= cmd.load_kind;
         ohandle_ff <= (cmd.load_kind == KIND_SENT) ? rd_data_ff : 16'd0;
         olevel_ff  <= (cmd.load_kind == KIND_SENT) ? 3'(pop_lvl_ff) : 3'd0;
         drop_ff    <= cmd.load_drop ? 4'(DROP_SAT) : 4'd0;
         last_ff    <= cmd.load_last;
      end
   end

   assign rsp_result_kind   = kind_ff;
   assign rsp_out_handle    = ohandle_ff;
   assign rsp_out_level     = olevel_ff;
   assign rsp_dropped_count = drop_ff;
   assign rsp_last_flag     = last_ff;

endmodule

>>> rtl/sppq_ctrl.sv
module sppq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [6:0]           req_send_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sppq_pkg::status_type status,
   output sppq_pkg::cmd_type    cmd
);
   import sppq_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RX       = 4'd1;
   localparam logic [3:0] ST_THIN_RD  = 4'd2;
   localparam logic [3:0] ST_THIN_WR  = 4'd3;
   localparam logic [3:0] ST_THIN_END = 4'd4;
   localparam logic [3:0] ST_TX_CHECK = 4'd5;
   localparam logic [3:0] ST_TX_POP   = 4'd6;
   localparam logic [3:0] ST_TX_DATA  = 4'd7;
   localparam logic [3:0] ST_OUT      = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [PW-1:0] k_ff, k_in;
   logic [6:0]    count_ff, count_in;
   logic [6:0]    limit_ff, limit_in;
   logic          done_ff, done_in;
   logic          valid_ff, valid_in;
   logic          accept;
   logic          last_tx;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign last_tx   = (count_ff + 7'd1 == limit_ff) || !status.any_nonempty;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      count_in = count_ff;
      limit_in = limit_ff;
      done_in  = done_ff;
      valid_in = valid_ff;
      cmd      = '0;
      cmd.k    = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               count_in  = 7'd0;
               limit_in  = (req_send_limit > 7'(MAX_SEND)) ? 7'(MAX_SEND) : req_send_limit;
               state_in  = (req_opcode == OP_SEND) ? ST_TX_CHECK : ST_RX;
            end
         end
         ST_RX: begin
            if (!status.in_range || !status.old_full) begin
               cmd.append    = status.in_range;
               cmd.load      = 1'b1;
               cmd.load_kind = KIND_ACK;
               cmd.load_last = 1'b1;
               done_in       = 1'b1;
               state_in      = ST_OUT;
            end else begin
               cmd.append = 1'b1;
               k_in       = PW'(1);
               state_in   = (KEPT > 1) ? ST_THIN_RD : ST_THIN_END;
            end
         end
         ST_THIN_RD: begin
            cmd.thin_rd = 1'b1;
            state_in    = ST_THIN_WR;
         end
         ST_THIN_WR: begin
            cmd.thin_wr = 1'b1;
            k_in        = k_ff + PW'(1);
            state_in    = (k_ff == PW'(KEPT - 1)) ? ST_THIN_END : ST_THIN_RD;
         end
         ST_THIN_END: begin
            cmd.thin_set  = 1'b1;
            cmd.load      = 1'b1;
            cmd.load_kind = KIND_ACK;
            cmd.load_drop = 1'b1;
            cmd.load_last = 1'b1;
            done_in       = 1'b1;
            state_in      = ST_OUT;
         end
         ST_TX_CHECK: begin
            if (limit_ff == 7'd0 || !status.any_nonempty) begin
               cmd.load      = 1'b1;
               cmd.load_kind = KIND_NOTHING;
               cmd.load_last = 1'b1;
               done_in       = 1'b1;
               state_in      = ST_OUT;
            end else begin
               state_in = ST_TX_POP;
            end
         end
         ST_TX_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_TX_DATA;
         end
         ST_TX_DATA: begin
            cmd.load      = 1'b1;
            cmd.load_kind = KIND_SENT;
            cmd.load_last = last_tx;
            done_in       = last_tx;
            count_in      = count_ff + 7'd1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (valid_ff && !rsp_stall) begin
               state_in = done_ff ? ST_IDLE : ST_TX_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Result valid follows loads and transfers.
      if (cmd.load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
         k_ff     <= '0;
         count_ff <= '0;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         done_ff  <= done_in;
         k_ff     <= k_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

endmodule

>>> rtl/strict_priority_packet_queue.sv
// Strict-priority packet queue: one FIFO of handles per priority level.
// Input channel req_*: an opcode of receive appends req_packet_handle to the
// queue of req_prio_level, and a full queue is then thinned to every other
// entry; an opcode of send emits up to req_send_limit handles, highest level
// first. Result channel rsp_*: one acknowledge per receive, one result per
// sent handle, or a single nothing-sent result; rsp_last_flag marks the final
// one of each item. A transfer happens when valid is high and stall is low.
// One item is in work at a time; req_stall stays high until its last result
// has been taken. A receive loads its result in ST_RX or, when it thins,
// moves the kept entries through ST_THIN_RD and ST_THIN_WR one at a time,
// since the slot memory has a single port, and then loads it in ST_THIN_END.
// A send passes ST_TX_CHECK once, then ST_TX_POP and ST_TX_DATA per handle for the
// registered memory read of each queue head. A stalled receiver holds the
// result register and the block waits. Synchronous reset empties all queues
// at once; slot contents are not cleared and are never read before written.
module strict_priority_packet_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [2:0]  req_prio_level,
   input  logic [15:0] req_packet_handle,
   input  logic [6:0]  req_send_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_out_handle,
   output logic [2:0]  rsp_out_level,
   output logic [3:0]  rsp_dropped_count,
   output logic        rsp_last_flag
);
   import sppq_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   sppq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_send_limit (req_send_limit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   // Queues and result register.
   sppq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_prio_level    (req_prio_level),
      .req_packet_handle (req_packet_handle),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_out_level     (rsp_out_level),
      .rsp_dropped_count (rsp_dropped_count),
      .rsp_last_flag     (rsp_last_flag)
   );

endmodule

>>> rtl/sppq_checker.sv
`include "strict_priority_packet_queue_assert.svh"

module sppq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [15:0] rsp_out_handle,
   input logic [2:0]  rsp_out_level,
   input logic        rsp_last_flag
);
   import sppq_pkg::*;

   // A stalled result stays put.
   `SPPQ_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_handle))

   // No new item is taken while a result is pending.
   `SPPQ_ASSERT_IMPLY(a_one_item, clock, reset, rsp_valid, req_stall)

   // A nothing-sent result always closes its item.
   `SPPQ_ASSERT_IMPLY(a_nothing_last, clock, reset, rsp_valid && rsp_result_kind == KIND_NOTHING, rsp_last_flag)

   // An acknowledge carries no handle and no level.
   `SPPQ_ASSERT_IMPLY(a_ack_zero, clock, reset, rsp_valid && rsp_result_kind == KIND_ACK, rsp_out_handle == 16'd0 && rsp_out_level == 3'd0)

   // The cycle after a transfer in, no result is shown yet.
   `SPPQ_ASSERT_NEXT(a_latency, clock, reset, req_valid && !req_stall, !rsp_valid)

endmodule

bind strict_priority_packet_queue sppq_checker u_sppq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_out_handle  (rsp_out_handle),
   .rsp_out_level   (rsp_out_level),
   .rsp_last_flag   (rsp_last_flag)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

import sppq_pkg::*;

// Expected results of the queue, kept by a predictor of its own.
class packet_queue_scoreboard;
   logic [15:0] slot_q[NUM_LEVELS][$];
   logic [1:0]  exp_kind[$];
   logic [15:0] exp_handle[$];
   logic [2:0]  exp_level[$];
   logic [3:0]  exp_drop[$];
   logic        exp_last[$];
   int          errors;

   function new();
      errors = 0;
   endfunction

   function void push_result(logic [1:0] kind, logic [15:0] h, logic [2:0] lv,
                             logic [3:0] d, logic last);
      exp_kind.push_back(kind);
      exp_handle.push_back(h);
      exp_level.push_back(lv);
      exp_drop.push_back(d);
      exp_last.push_back(last);
   endfunction

   function int pending();
      return exp_kind.size();
   endfunction

   // Notes an accepted input transfer and predicts its results.
   function void note_input(logic op, logic [2:0] lv, logic [15:0] h, logic [6:0] lim);
      logic [15:0] kept[$];
      int n;
      int cnt;
      int top;
      if (op == OP_RECV) begin
         n = 0;
         if (lv < NUM_LEVELS) begin
            if (slot_q[lv].size() < SLOTS) slot_q[lv].push_back(h);
            if (slot_q[lv].size() > QUEUE_LIMIT) begin
               kept = {};
               for (int i = 0; i < slot_q[lv].size(); i += 2) kept.push_back(slot_q[lv][i]);
               n = slot_q[lv].size() - kept.size();
               slot_q[lv] = kept;
            end
         end
         if (n > 15) n = 15;
         push_result(KIND_ACK, 16'd0, 3'd0, 4'(n), 1'b1);
      end else begin
         cnt = 0;
         if (lim > MAX_SEND) lim = MAX_SEND;
         while (cnt < lim) begin
            top = -1;
            for (int l = NUM_LEVELS - 1; l >= 0; l--)
               if (top < 0 && slot_q[l].size() != 0) top = l;
            if (top < 0) break;
            push_result(KIND_SENT, slot_q[top].pop_front(), 3'(top), 4'd0, 1'b0);
            cnt++;
         end
         if (cnt == 0) push_result(KIND_NOTHING, 16'd0, 3'd0, 4'd0, 1'b1);
         else exp_last[exp_last.size() - 1] = 1'b1;
      end
   endfunction

   // Compares one result transfer with the oldest expectation.
   function void check_result(logic [1:0] kind, logic [15:0] h, logic [2:0] lv,
                              logic [3:0] d, logic last);
      if (exp_kind.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual kind %0d handle %h",
                  $time, kind, h);
         errors++;
         return;
      end
      if (kind !== exp_kind[0]) begin
         $display("%0t: kind expected %0d actual %0d", $time, exp_kind[0], kind);
         errors++;
      end
      if (h !== exp_handle[0]) begin
         $display("%0t: handle expected %h actual %h", $time, exp_handle[0], h);
         errors++;
      end
      if (lv !== exp_level[0]) begin
         $display("%0t: level expected %0d actual %0d", $time, exp_level[0], lv);
         errors++;
      end
      if (d !== exp_drop[0]) begin
         $display("%0t: dropped expected %0d actual %0d", $time, exp_drop[0], d);
         errors++;
      end
      if (last !== exp_last[0]) begin
         $display("%0t: last expected %0d actual %0d", $time, exp_last[0], last);
         errors++;
      end
      void'(exp_kind.pop_front());
      void'(exp_handle.pop_front());
      void'(exp_level.pop_front());
      void'(exp_drop.pop_front());
      void'(exp_last.pop_front());
   endfunction
endclass

module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = 1'b0;
   logic [2:0]  req_prio_level = 3'd0;
   logic [15:0] req_packet_handle = 16'd0;
   logic [6:0]  req_send_limit = 7'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_out_handle;
   logic [2:0]  rsp_out_level;
   logic [3:0]  rsp_dropped_count;
   logic        rsp_last_flag;

   packet_queue_scoreboard sb = new();
   bit sending_done = 0;
   int stall_hold = 0;
   int stall_quiet = 0;
   bit mode_gaps = 1;
   int burst_handle = 0;

   strict_priority_packet_queue uut (.*);

   always #1 clock = ~clock;

   // Both channels are sampled at the clock edge; results checked on transfer.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_input(req_opcode, req_prio_level, req_packet_handle, req_send_limit);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_result_kind, rsp_out_handle, rsp_out_level,
                         rsp_dropped_count, rsp_last_flag);
   end

   // Offers one item, after a random gap when gaps are on, and holds it until transferred.
   task automatic send_item(logic op, logic [2:0] lv, logic [15:0] h, logic [6:0] lim);
      int gap;
      gap = mode_gaps ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_prio_level <= lv;
      req_packet_handle <= h;
      req_send_limit <= lim;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic rand_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 62)
         send_item(OP_RECV, 3'($urandom_range(0, 7)), 16'($urandom), 7'($urandom));
      else if (r < 90)
         send_item(OP_SEND, 3'($urandom), 16'($urandom), 7'($urandom_range(0, 6)));
      else
         send_item(OP_SEND, 3'($urandom), 16'($urandom), 7'($urandom_range(0, 127)));
   endtask

   // Receiver: random stall per result, one long hold-off, and quiet stretches.
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (stall_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_hold) @(posedge clock);
            stall_hold = 0;
         end
         w = (stall_quiet > 0) ? 0 : $urandom_range(0, 17);
         if (stall_quiet > 0) stall_quiet--;
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Directed part, then random items, then drain.
   initial begin
      int waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // Empty queues and a zero limit each give a nothing-sent result.
      send_item(OP_SEND, 3'd0, 16'd0, 7'd5);
      send_item(OP_SEND, 3'd7, 16'hFFFF, 7'd0);
      // Fill level 3 past its limit so it thins once, then add one more.
      for (int i = 0; i < 10; i++) send_item(OP_RECV, 3'd3, 16'(16'h3000 + i), 7'd127);
      send_item(OP_RECV, 3'd7, 16'hFFFF, 7'd0);
      send_item(OP_RECV, 3'd0, 16'h0000, 7'd64);
      send_item(OP_RECV, 3'd5, 16'hA5A5, 7'd1);
      // Empty levels are skipped; large limits saturate.
      send_item(OP_SEND, 3'd0, 16'd0, 7'd2);
      send_item(OP_SEND, 3'd0, 16'd0, 7'd127);
      send_item(OP_SEND, 3'd0, 16'd0, 7'd64);
      // Long hold-off while items keep coming so the block backs up.
      stall_hold = 300;
      for (int i = 0; i < 6; i++) send_item(OP_RECV, 3'(i), 16'($urandom), 7'd0);
      for (int i = 0; i < 420; i++) begin
         if (i % 100 == 50) begin
            mode_gaps = 0;
            stall_quiet = 20;
         end
         if (i % 100 == 70) mode_gaps = 1;
         rand_item();
      end
      send_item(OP_SEND, 3'd0, 16'd0, 7'd64);
      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl
rtl/sppq_pkg.sv
rtl/sppq_datapath.sv
rtl/sppq_ctrl.sv
rtl/strict_priority_packet_queue.sv
rtl/sppq_checker.sv
dv/tb_top.sv
